// File: rtl/core/midi_note_to_gamepad_report_defines.svh
// Assertion macros shared by the MIDI note to gamepad report block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef MIDI_NOTE_TO_GAMEPAD_REPORT_DEFINES_SVH
`define MIDI_NOTE_TO_GAMEPAD_REPORT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MNGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MNGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mngr_pkg.sv
// Package for the MIDI note to gamepad report block: constants, key table,
// queue entry and status types. No dependencies.
`default_nettype none

package mngr_pkg;

  // Key set and note table.
  localparam int unsigned MAX_KEYS         = 15;
  localparam int unsigned NUM_KEYS_DEFAULT = 15;
  localparam logic [7:0] KEY_NOTES [MAX_KEYS] = '{
    8'd60, 8'd62, 8'd64, 8'd65, 8'd67, 8'd69, 8'd71, 8'd72,
    8'd74, 8'd76, 8'd77, 8'd79, 8'd81, 8'd83, 8'd84
  };

  // Key codes for the gamepad controls.
  localparam logic [3:0] KEY_LT     = 4'd0;
  localparam logic [3:0] KEY_RT     = 4'd1;
  localparam logic [3:0] KEY_DDOWN  = 4'd2;
  localparam logic [3:0] KEY_B0     = 4'd3;
  localparam logic [3:0] KEY_DLEFT  = 4'd4;
  localparam logic [3:0] KEY_B2     = 4'd5;
  localparam logic [3:0] KEY_DUP    = 4'd6;
  localparam logic [3:0] KEY_B3     = 4'd7;
  localparam logic [3:0] KEY_DRIGHT = 4'd8;
  localparam logic [3:0] KEY_B1     = 4'd9;
  localparam logic [3:0] KEY_B4     = 4'd10;
  localparam logic [3:0] KEY_B5     = 4'd11;
  localparam logic [3:0] KEY_LSX_LO = 4'd12;
  localparam logic [3:0] KEY_RSX_LO = 4'd13;
  localparam logic [3:0] KEY_LSX_HI = 4'd14;

  // D-pad bit positions.
  localparam int unsigned DP_UP    = 0;
  localparam int unsigned DP_DOWN  = 1;
  localparam int unsigned DP_LEFT  = 2;
  localparam int unsigned DP_RIGHT = 3;

  // Input command codes and MIDI decoding.
  localparam logic       CMD_MIDI       = 1'b0;
  localparam logic       CMD_TICK       = 1'b1;
  localparam logic [3:0] NOTE_ON_NIBBLE = 4'h9;

  // Control values.
  localparam logic [7:0] HOLD_TICKS_RESET = 8'd8;
  localparam logic [7:0] STICK_CENTRE     = 8'd128;
  localparam logic [7:0] STICK_LOW        = 8'd0;
  localparam logic [7:0] STICK_HIGH       = 8'd255;
  localparam logic [7:0] TRIGGER_FULL     = 8'd255;

  // Frame layout.
  localparam logic [7:0] FRAME_TAG    = 8'hA0;
  localparam logic [7:0] FRAME_LENGTH = 8'd12;
  localparam logic [7:0] FRAME_HEADER = 8'hC0;
  localparam logic [3:0] BYTE_TAG     = 4'd0;
  localparam logic [3:0] BYTE_LEN     = 4'd1;
  localparam logic [3:0] BYTE_HDR     = 4'd2;
  localparam logic [3:0] BYTE_BTN_LO  = 4'd3;
  localparam logic [3:0] BYTE_BTN_HI  = 4'd4;
  localparam logic [3:0] BYTE_PAD_A   = 4'd5;
  localparam logic [3:0] BYTE_PAD_B   = 4'd6;
  localparam logic [3:0] BYTE_DPAD    = 4'd7;
  localparam logic [3:0] BYTE_LSX     = 4'd8;
  localparam logic [3:0] BYTE_LSY     = 4'd9;
  localparam logic [3:0] BYTE_RSX     = 4'd10;
  localparam logic [3:0] BYTE_RSY     = 4'd11;
  localparam logic [3:0] BYTE_LTRIG   = 4'd12;
  localparam logic [3:0] BYTE_RTRIG   = 4'd13;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_NOTE,
    KIND_TICK
  } item_kind_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] note;
  } queue_entry_t;

  // Controller state exposed for checking.
  typedef struct packed {
    logic [3:0] dpad;
    logic [7:0] left_stick;
  } back_status_t;

endpackage

`default_nettype wire

// File: rtl/core/mngr_front.sv
// Front end: accepts stream items and classifies them into ticks and
// matched note-on events for the queue. Depends on mngr_pkg.
`default_nettype none

module mngr_front
  import mngr_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEFAULT
) (
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [7:0] status_byte, [15:8] note_byte, [23:16] velocity_byte
  input  wire logic [23:0]  s_axis_tdata,
  // [0] cmd
  input  wire logic         s_axis_tuser,
  input  wire logic         queue_full_i,
  output logic              push_o,
  output queue_entry_t      push_entry_o
);

  logic [7:0] status_b;
  logic [7:0] note_b;
  logic [7:0] vel_b;
  logic       note_hit;
  logic       note_on;

  assign status_b = s_axis_tdata[7:0];
  assign note_b   = s_axis_tdata[15:8];
  assign vel_b    = s_axis_tdata[23:16];

  // Does the note number belong to one of the active keys?
  always_comb begin
    note_hit = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (KEY_NOTES[i] == note_b) begin
        note_hit = 1'b1;
      end
    end
  end

  assign note_on = (status_b[7:4] == NOTE_ON_NIBBLE) && (vel_b != 8'd0);

  // Accept whenever the queue has room; only ticks and useful notes go on.
  assign s_axis_tready = !queue_full_i;
  assign push_o = s_axis_tvalid && s_axis_tready &&
                  ((s_axis_tuser == CMD_TICK) || (note_on && note_hit));

  always_comb begin
    push_entry_o.kind = (s_axis_tuser == CMD_TICK) ? KIND_TICK : KIND_NOTE;
    push_entry_o.note = note_b;
  end

endmodule

`default_nettype wire

// File: rtl/core/mngr_queue.sv
// Short in-order queue between the front end and the controller.
// Depends on mngr_pkg.
`default_nettype none

module mngr_queue
  import mngr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire queue_entry_t push_entry_i,
  input  wire logic   pop_i,
  output queue_entry_t head_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t           entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q;
  logic [PTR_W-1:0]       rd_ptr_q;
  logic [CNT_W-1:0]       count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/mngr_back.sv
// Controller back end: pending marks, hold counters, control state, the
// per-tick key scan and frame emission through an output register.
// Depends on mngr_pkg.
`default_nettype none

module mngr_back
  import mngr_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        q_empty_i,
  input  wire queue_entry_t q_head_i,
  output logic             q_pop_o,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast,
  output back_status_t     status_o
);

  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECR,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [7:0]        hold_ticks_q;
  logic              pending_q [NUM_KEYS];
  logic [7:0]        hold_q    [NUM_KEYS];
  logic [5:0]        buttons_q;
  logic [3:0]        dpad_q;
  logic [7:0]        lsx_q;
  logic [7:0]        rsx_q;
  logic              lt_q;
  logic              rt_q;
  logic [3:0]        seq_q;
  logic [KW-1:0]     scan_q;
  logic [3:0]        byte_q;
  logic              out_valid_q;
  logic [7:0]        out_data_q;
  logic              out_last_q;

  logic [MAX_KEYS-1:0] rel;
  logic [3:0]          key;
  logic                allow;
  logic                do_press;
  logic [7:0]          hold_load;
  logic                out_load;
  logic [7:0]          frame_byte;

  // Counters about to expire release their controls this tick.
  always_comb begin
    rel = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      rel[i] = (hold_q[i] == 8'd1);
    end
  end

  // Press check for the key under scan.
  assign key = 4'(scan_q);
  always_comb begin
    unique case (key)
      KEY_DDOWN:  allow = !dpad_q[DP_UP];
      KEY_DLEFT:  allow = !dpad_q[DP_RIGHT];
      KEY_DUP:    allow = !dpad_q[DP_DOWN];
      KEY_DRIGHT: allow = !dpad_q[DP_LEFT];
      KEY_LSX_LO,
      KEY_LSX_HI: allow = (lsx_q == STICK_CENTRE);
      default:    allow = 1'b1;
    endcase
  end

  assign do_press  = pending_q[scan_q] && (hold_q[scan_q] == 8'd0) && allow;
  assign hold_load = (hold_ticks_q == 8'd0) ? 8'd1 : hold_ticks_q;

  // Frame byte selected by the byte counter.
  always_comb begin
    case (byte_q)
      BYTE_TAG:    frame_byte = FRAME_TAG + {4'd0, seq_q};
      BYTE_LEN:    frame_byte = FRAME_LENGTH;
      BYTE_HDR:    frame_byte = FRAME_HEADER;
      BYTE_BTN_LO: frame_byte = {2'b00, buttons_q};
      BYTE_BTN_HI: frame_byte = 8'd0;
      BYTE_PAD_A:  frame_byte = 8'd0;
      BYTE_PAD_B:  frame_byte = 8'd0;
      BYTE_DPAD:   frame_byte = {4'd0, dpad_q};
      BYTE_LSX:    frame_byte = lsx_q;
      BYTE_LSY:    frame_byte = STICK_CENTRE;
      BYTE_RSX:    frame_byte = rsx_q;
      BYTE_RSY:    frame_byte = STICK_CENTRE;
      BYTE_LTRIG:  frame_byte = lt_q ? TRIGGER_FULL : 8'd0;
      BYTE_RTRIG:  frame_byte = rt_q ? TRIGGER_FULL : 8'd0;
      default:     frame_byte = 8'd0;
    endcase
  end

  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);
  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;

  // Sequencer, control state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hold_ticks_q <= HOLD_TICKS_RESET;
      for (int i = 0; i < NUM_KEYS; i++) begin
        pending_q[i] <= 1'b0;
        hold_q[i]    <= 8'd0;
      end
      buttons_q   <= '0;
      dpad_q      <= '0;
      lsx_q       <= STICK_CENTRE;
      rsx_q       <= STICK_CENTRE;
      lt_q        <= 1'b0;
      rt_q        <= 1'b0;
      seq_q       <= '0;
      scan_q      <= '0;
      byte_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hold_ticks_q <= cfg_wdata_i;
      end

      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            if (q_head_i.kind == KIND_TICK) begin
              state_q <= ST_DECR;
            end else begin
              for (int i = 0; i < NUM_KEYS; i++) begin
                if (KEY_NOTES[i] == q_head_i.note) begin
                  pending_q[i] <= 1'b1;
                end
              end
            end
          end
        end

        // All counters step down together; expired ones release.
        ST_DECR: begin
          for (int i = 0; i < NUM_KEYS; i++) begin
            if (hold_q[i] != 8'd0) begin
              hold_q[i] <= hold_q[i] - 8'd1;
            end
          end
          if (rel[KEY_LT]) lt_q <= 1'b0;
          if (rel[KEY_RT]) rt_q <= 1'b0;
          if (rel[KEY_DUP])    dpad_q[DP_UP]    <= 1'b0;
          if (rel[KEY_DDOWN])  dpad_q[DP_DOWN]  <= 1'b0;
          if (rel[KEY_DLEFT])  dpad_q[DP_LEFT]  <= 1'b0;
          if (rel[KEY_DRIGHT]) dpad_q[DP_RIGHT] <= 1'b0;
          if (rel[KEY_B0]) buttons_q[0] <= 1'b0;
          if (rel[KEY_B1]) buttons_q[1] <= 1'b0;
          if (rel[KEY_B2]) buttons_q[2] <= 1'b0;
          if (rel[KEY_B3]) buttons_q[3] <= 1'b0;
          if (rel[KEY_B4]) buttons_q[4] <= 1'b0;
          if (rel[KEY_B5]) buttons_q[5] <= 1'b0;
          if (rel[KEY_LSX_LO] || rel[KEY_LSX_HI]) lsx_q <= STICK_CENTRE;
          if (rel[KEY_RSX_LO]) rsx_q <= STICK_CENTRE;
          scan_q  <= '0;
          state_q <= ST_SCAN;
        end

        // One key per cycle, in index order.
        ST_SCAN: begin
          if (do_press) begin
            pending_q[scan_q] <= 1'b0;
            hold_q[scan_q]    <= hold_load;
            unique case (key)
              KEY_LT:     lt_q <= 1'b1;
              KEY_RT:     rt_q <= 1'b1;
              KEY_DDOWN:  dpad_q[DP_DOWN]  <= 1'b1;
              KEY_DLEFT:  dpad_q[DP_LEFT]  <= 1'b1;
              KEY_DUP:    dpad_q[DP_UP]    <= 1'b1;
              KEY_DRIGHT: dpad_q[DP_RIGHT] <= 1'b1;
              KEY_B0:     buttons_q[0] <= 1'b1;
              KEY_B1:     buttons_q[1] <= 1'b1;
              KEY_B2:     buttons_q[2] <= 1'b1;
              KEY_B3:     buttons_q[3] <= 1'b1;
              KEY_B4:     buttons_q[4] <= 1'b1;
              KEY_B5:     buttons_q[5] <= 1'b1;
              KEY_LSX_LO: lsx_q <= STICK_LOW;
              KEY_LSX_HI: lsx_q <= STICK_HIGH;
              KEY_RSX_LO: rsx_q <= STICK_LOW;
              default:    lt_q  <= lt_q;
            endcase
          end
          if (scan_q == KW'(NUM_KEYS - 1)) begin
            byte_q  <= BYTE_TAG;
            state_q <= ST_EMIT;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end

        // Frame bytes go out one per transfer.
        ST_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_data_q  <= frame_byte;
            out_last_q  <= (byte_q == BYTE_RTRIG);
            if (byte_q == BYTE_RTRIG) begin
              seq_q   <= seq_q + 4'd1;
              state_q <= ST_IDLE;
            end else begin
              byte_q <= byte_q + 4'd1;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    status_o.dpad       = dpad_q;
    status_o.left_stick = lsx_q;
  end

endmodule

`default_nettype wire

// File: rtl/core/midi_note_to_gamepad_report.sv
// Top level of the MIDI note to gamepad report block: front end, queue and
// controller. Depends on mngr_pkg, mngr_front, mngr_queue, mngr_back.
//
// MIDI note-on messages on the input stream mark keys as pending; each tick
// steps the hold counters, scans the keys and sends a 14-byte report frame
// on the output stream, tlast on its final byte. Input items pass through a
// two-entry queue, so the input keeps accepting while the controller works
// as long as the queue has room. The controller pops a MIDI message from the
// head of the queue and marks its key pending as it pops it. A tick is popped,
// then all hold counters step down together, the scan sequencer visits the
// keys in index order, and the frame bytes go out through the single output
// register, waiting while the output is stalled. hold_ticks may only be
// written while the block is idle.
`default_nettype none

`include "midi_note_to_gamepad_report_defines.svh"

module midi_note_to_gamepad_report
  import mngr_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: hold_ticks
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // Input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [7:0] status_byte, [15:8] note_byte, [23:16] velocity_byte
  input  wire logic [23:0] s_axis_tdata_i,
  // [0] cmd
  input  wire logic        s_axis_tuser_i,
  // Output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] frame_byte
  output logic [7:0]       m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  logic         q_push;
  queue_entry_t q_push_entry;
  logic         q_pop;
  queue_entry_t q_head;
  logic         q_full;
  logic         q_empty;
  back_status_t status;

  // Classify incoming items.
  mngr_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid_i),
    .s_axis_tready (s_axis_tready_o),
    .s_axis_tdata  (s_axis_tdata_i),
    .s_axis_tuser  (s_axis_tuser_i),
    .queue_full_i  (q_full),
    .push_o        (q_push),
    .push_entry_o  (q_push_entry)
  );

  // Decoupling queue.
  mngr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  // Carry out notes and ticks.
  mngr_back #(
    .NUM_KEYS (NUM_KEYS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid_o),
    .m_axis_tready (m_axis_tready_i),
    .m_axis_tdata  (m_axis_tdata_o),
    .m_axis_tlast  (m_axis_tlast_o),
    .status_o      (status)
  );

  // Checks on the controller.
  `MNGR_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty, "pop from an empty queue")
  `MNGR_ASSERT_IMP(a_dpad_vertical, status.dpad[DP_UP], !status.dpad[DP_DOWN],
                   "d-pad up and down both held")
  `MNGR_ASSERT_IMP(a_dpad_horizontal, status.dpad[DP_LEFT], !status.dpad[DP_RIGHT],
                   "d-pad left and right both held")
  `MNGR_ASSERT_IMP(a_last_is_trigger, m_axis_tvalid_o && m_axis_tlast_o,
                   (m_axis_tdata_o == 8'd0) || (m_axis_tdata_o == TRIGGER_FULL),
                   "final frame byte is not a trigger value")

endmodule

`default_nettype wire
